FILE: rtl/core/mmp_pkg.sv
// Shared types, constants and helpers for the modular matrix power block.
package mmp_pkg;

  localparam int MaxSize   = 8;
  localparam int IdxW      = 3;
  localparam int CellW     = 2 * IdxW;
  localparam int Cells     = MaxSize * MaxSize;
  localparam int ValW      = 31;
  localparam int SizeW     = 4;
  localparam int WmAddrW   = 2 + CellW;
  localparam int WmDepth   = 3 * Cells;
  localparam int MulSteps  = ValW;
  localparam int MulCntW   = 5;
  localparam logic [ValW-1:0]  ModReset  = 31'd1000000007;
  localparam logic [SizeW-1:0] SizeReset = 4'd2;

  typedef enum logic {
    CFG_MODULUS,
    CFG_SIZE
  } cfg_e;

  typedef enum logic [1:0] {
    RG_BASE,
    RG_RES,
    RG_PROD
  } region_e;

  typedef enum logic [1:0] {
    WS_ACC,
    WS_PORTA,
    WS_DIAG
  } wsel_e;

  typedef enum logic [1:0] {
    PH_BASE_INIT,
    PH_RES_MUL,
    PH_BASE_MUL
  } phase_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RES_INIT,
    ST_MUL_RD,
    ST_MUL_GO,
    ST_MUL_WAIT,
    ST_MUL_ACC,
    ST_CP_RD,
    ST_CP_WR,
    ST_BIT,
    ST_EM_RD,
    ST_EM_OUT
  } state_e;

  typedef struct packed {
    logic               a_from_src;
    logic [CellW-1:0]   src_addr;
    logic [WmAddrW-1:0] a_addr;
    logic [WmAddrW-1:0] b_addr;
    logic               b_one;
    logic               mul_start;
    logic               acc_first;
    logic               acc_en;
    logic               wr_en;
    wsel_e              wr_sel;
    logic               diag;
    logic [WmAddrW-1:0] wr_addr;
    logic               emit;
    logic [IdxW-1:0]    row;
    logic [IdxW-1:0]    col;
    logic               last;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_done;
  } dp_sts_t;

  function automatic logic [WmAddrW-1:0] wm_addr(region_e rg, logic [IdxW-1:0] r,
                                                 logic [IdxW-1:0] c);
    wm_addr = {rg, r, c};
  endfunction

endpackage

FILE: rtl/core/modular_matrix_power.sv
// Top level of the modular matrix power block: configuration registers and wiring.
//
// Input words are offered on start with their fields and taken when busy is low.
// A load word (operation 0) writes one source entry into the source store;
// busy stays low. A run word (operation 1) raises the leading size by size block
// of the source matrix to the given power modulo the modulus register.
// The run begins from the identity, reduces the source into the base store, and
// for every exponent bit up to the highest set one performs an optional result
// product and a base squaring, each followed by a copy. Every matrix entry of a
// product sums n inner terms, each formed by the bit-serial multiplier; a run
// performs up to 62 products, plus the setup, the reduction of the source and
// a copy after each product.
// Results then appear as n*n words in row-major order, each marked by
// result_valid_o for a single cycle, with last_o on the final one.
// The receiver cannot stall; every word must be taken when shown.
// Configuration must be written over the APB-style port only while busy is low
// (the block does not enforce it). Reset clears the source matrix to zero, sets
// the modulus to 1000000007 and the size to 2, and returns the controller to idle.
module modular_matrix_power import mmp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  logic             start,
  output logic             busy,
  input  logic             operation_i,
  input  logic [IdxW-1:0]  row_i,
  input  logic [IdxW-1:0]  col_i,
  input  logic [ValW-1:0]  value_i,
  input  logic [ValW-1:0]  power_i,
  output logic             result_valid_o,
  output logic [IdxW-1:0]  out_row_o,
  output logic [IdxW-1:0]  out_col_o,
  output logic [ValW-1:0]  out_value_o,
  output logic             last_o
);

  logic [ValW-1:0]  mod_q;
  logic [SizeW-1:0] size_q;
  logic [ValW-1:0]  mod_eff;
  logic             cfg_we;
  cfg_e             cfg_idx;
  dp_cmd_t          cmd;
  dp_sts_t          sts;
  logic             src_we;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign cfg_idx = cfg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q  <= ModReset;
      size_q <= SizeReset;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_MODULUS: mod_q  <= pwdata[ValW-1:0];
        CFG_SIZE:    size_q <= pwdata[SizeW-1:0];
        default:     mod_q  <= mod_q;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      CFG_MODULUS: prdata = {1'b0, mod_q};
      CFG_SIZE:    prdata = {28'd0, size_q};
      default:     prdata = '0;
    endcase
  end

  assign mod_eff = (mod_q == '0) ? ValW'(1) : mod_q;
  assign src_we  = start & ~busy & ~operation_i;

  mmp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .operation_i (operation_i),
    .power_i     (power_i),
    .size_i      (size_q),
    .busy_o      (busy),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  mmp_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .mod_i       (mod_eff),
    .src_we_i    (src_we),
    .src_addr_i  ({row_i, col_i}),
    .src_data_i  (value_i),
    .out_valid_o (result_valid_o),
    .out_row_o   (out_row_o),
    .out_col_o   (out_col_o),
    .out_value_o (out_value_o),
    .out_last_o  (last_o)
  );

  // A run keeps the block busy from the cycle after it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && operation_i) |=> busy)
    else $error("run word did not raise busy");

  // Result words other than the last arrive while the run is still in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_o) |-> busy)
    else $error("result word outside a run");

  // Result words never appear in back-to-back cycles.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("back-to-back result words");

  // The last flag only marks a valid result word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> result_valid_o)
    else $error("last without a result word");

endmodule

FILE: rtl/core/mmp_dpath.sv
// Datapath: entry stores, work memory, serial modular multiplier and accumulator.
module mmp_dpath import mmp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dp_cmd_t          cmd_i,
  output dp_sts_t          sts_o,
  input  logic [ValW-1:0]  mod_i,
  input  logic             src_we_i,
  input  logic [CellW-1:0] src_addr_i,
  input  logic [ValW-1:0]  src_data_i,
  output logic             out_valid_o,
  output logic [IdxW-1:0]  out_row_o,
  output logic [IdxW-1:0]  out_col_o,
  output logic [ValW-1:0]  out_value_o,
  output logic             out_last_o
);

  logic [ValW-1:0]    src_mem [Cells];
  logic [Cells-1:0]   src_vld_q;
  logic [ValW-1:0]    src_rd_q;
  logic [ValW-1:0]    wm_mem [WmDepth];
  logic [ValW-1:0]    rda_q, rdb_q;
  logic [ValW-1:0]    one_mod;
  logic [ValW-1:0]    ma_q, mb_q, macc_q, macc_d;
  logic [MulCntW-1:0] mcnt_q;
  logic               mbusy_q, mdone_q;
  logic [ValW:0]      dbl, dbl_r, add, add_r;
  logic [ValW-1:0]    sacc_q;
  logic [ValW:0]      sum, sum_r;
  logic [ValW-1:0]    wr_data;
  logic               out_valid_q, out_last_q;
  logic [IdxW-1:0]    out_row_q, out_col_q;
  logic [ValW-1:0]    out_value_q;

  assign one_mod = (mod_i == ValW'(1)) ? '0 : ValW'(1);

  always_ff @(posedge clk_i) begin
    if (src_we_i) begin
      src_mem[src_addr_i] <= src_data_i;
    end
    src_rd_q <= src_vld_q[cmd_i.src_addr] ? src_mem[cmd_i.src_addr] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_vld_q <= '0;
    end else if (src_we_i) begin
      src_vld_q[src_addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      wm_mem[cmd_i.wr_addr] <= wr_data;
    end
    rda_q <= wm_mem[cmd_i.a_addr];
    rdb_q <= wm_mem[cmd_i.b_addr];
  end

  always_comb begin
    dbl   = {macc_q, 1'b0};
    dbl_r = (dbl >= {1'b0, mod_i}) ? dbl - {1'b0, mod_i} : dbl;
    add   = dbl_r + (ma_q[ValW-1] ? {1'b0, mb_q} : '0);
    add_r = (add >= {1'b0, mod_i}) ? add - {1'b0, mod_i} : add;
    macc_d = add_r[ValW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mbusy_q <= 1'b0;
      mdone_q <= 1'b0;
      mcnt_q  <= '0;
    end else begin
      mdone_q <= 1'b0;
      if (cmd_i.mul_start) begin
        mbusy_q <= 1'b1;
        mcnt_q  <= '0;
      end else if (mbusy_q) begin
        mcnt_q <= mcnt_q + MulCntW'(1);
        if (mcnt_q == MulCntW'(MulSteps - 1)) begin
          mbusy_q <= 1'b0;
          mdone_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_start) begin
      ma_q   <= cmd_i.a_from_src ? src_rd_q : rda_q;
      mb_q   <= cmd_i.b_one ? one_mod : rdb_q;
      macc_q <= '0;
    end else if (mbusy_q) begin
      ma_q   <= {ma_q[ValW-2:0], 1'b0};
      macc_q <= macc_d;
    end
  end

  always_comb begin
    sum   = (cmd_i.acc_first ? '0 : {1'b0, sacc_q}) + {1'b0, macc_q};
    sum_r = (sum >= {1'b0, mod_i}) ? sum - {1'b0, mod_i} : sum;
    case (cmd_i.wr_sel)
      WS_ACC:   wr_data = sum_r[ValW-1:0];
      WS_PORTA: wr_data = rda_q;
      WS_DIAG:  wr_data = cmd_i.diag ? one_mod : '0;
      default:  wr_data = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_en) begin
      sacc_q <= sum_r[ValW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      out_valid_q <= cmd_i.emit;
      out_last_q  <= cmd_i.emit & cmd_i.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_row_q   <= cmd_i.row;
      out_col_q   <= cmd_i.col;
      out_value_q <= rda_q;
    end
  end

  assign sts_o.mul_done = mdone_q;
  assign out_valid_o    = out_valid_q;
  assign out_last_o     = out_last_q;
  assign out_row_o      = out_row_q;
  assign out_col_o      = out_col_q;
  assign out_value_o    = out_value_q;

endmodule

FILE: rtl/core/mmp_ctrl.sv
// Controller: sequences initialization, matrix products, copies and emission.
module mmp_ctrl import mmp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             operation_i,
  input  logic [ValW-1:0]  power_i,
  input  logic [SizeW-1:0] size_i,
  output logic             busy_o,
  output dp_cmd_t          cmd_o,
  input  dp_sts_t          sts_i
);

  state_e          state_q, state_d;
  phase_e          phase_q, phase_d;
  logic [ValW-1:0] pw_q, pw_d;
  logic [IdxW-1:0] nl_q, nl_d;
  logic [IdxW-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic [IdxW-1:0] klast;
  logic            wrap;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_BASE_INIT;
      pw_q    <= '0;
      nl_q    <= '0;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      pw_q    <= pw_d;
      nl_q    <= nl_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
    end
  end

  assign klast  = (phase_q == PH_BASE_INIT) ? '0 : nl_q;
  assign wrap   = (i_q == nl_q) && (j_q == nl_q);
  assign busy_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    pw_d    = pw_q;
    nl_d    = nl_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;

    cmd_o            = '0;
    cmd_o.a_from_src = (phase_q == PH_BASE_INIT);
    cmd_o.b_one      = (phase_q == PH_BASE_INIT);
    cmd_o.src_addr   = {i_q, j_q};
    cmd_o.row        = i_q;
    cmd_o.col        = j_q;
    cmd_o.last       = wrap;
    cmd_o.diag       = (i_q == j_q);
    cmd_o.wr_sel     = WS_ACC;
    case (phase_q)
      PH_RES_MUL: begin
        cmd_o.a_addr = wm_addr(RG_RES, i_q, k_q);
        cmd_o.b_addr = wm_addr(RG_BASE, k_q, j_q);
      end
      default: begin
        cmd_o.a_addr = wm_addr(RG_BASE, i_q, k_q);
        cmd_o.b_addr = wm_addr(RG_BASE, k_q, j_q);
      end
    endcase

    case (state_q)
      ST_IDLE: begin
        if (start_i && operation_i) begin
          pw_d = power_i;
          if (size_i == '0) begin
            nl_d = '0;
          end else if (size_i > SizeW'(MaxSize)) begin
            nl_d = IdxW'(MaxSize - 1);
          end else begin
            nl_d = IdxW'(size_i - SizeW'(1));
          end
          i_d     = '0;
          j_d     = '0;
          k_d     = '0;
          state_d = ST_RES_INIT;
        end
      end
      ST_RES_INIT: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_sel  = WS_DIAG;
        cmd_o.wr_addr = wm_addr(RG_RES, i_q, j_q);
        j_d = (j_q == nl_q) ? '0 : j_q + IdxW'(1);
        i_d = (j_q == nl_q) ? i_q + IdxW'(1) : i_q;
        if (wrap) begin
          i_d     = '0;
          phase_d = PH_BASE_INIT;
          state_d = ST_MUL_RD;
        end
      end
      ST_MUL_RD: begin
        state_d = ST_MUL_GO;
      end
      ST_MUL_GO: begin
        cmd_o.mul_start = 1'b1;
        state_d = ST_MUL_WAIT;
      end
      ST_MUL_WAIT: begin
        if (sts_i.mul_done) begin
          state_d = ST_MUL_ACC;
        end
      end
      ST_MUL_ACC: begin
        cmd_o.acc_en    = 1'b1;
        cmd_o.acc_first = (k_q == '0);
        state_d = ST_MUL_RD;
        if (k_q == klast) begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_addr = (phase_q == PH_BASE_INIT) ? wm_addr(RG_BASE, i_q, j_q)
                                                    : wm_addr(RG_PROD, i_q, j_q);
          k_d = '0;
          j_d = (j_q == nl_q) ? '0 : j_q + IdxW'(1);
          i_d = (j_q == nl_q) ? i_q + IdxW'(1) : i_q;
          if (wrap) begin
            i_d     = '0;
            state_d = (phase_q == PH_BASE_INIT) ? ST_BIT : ST_CP_RD;
          end
        end else begin
          k_d = k_q + IdxW'(1);
        end
      end
      ST_CP_RD: begin
        cmd_o.a_addr = wm_addr(RG_PROD, i_q, j_q);
        state_d = ST_CP_WR;
      end
      ST_CP_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_sel  = WS_PORTA;
        cmd_o.wr_addr = (phase_q == PH_RES_MUL) ? wm_addr(RG_RES, i_q, j_q)
                                                : wm_addr(RG_BASE, i_q, j_q);
        j_d = (j_q == nl_q) ? '0 : j_q + IdxW'(1);
        i_d = (j_q == nl_q) ? i_q + IdxW'(1) : i_q;
        state_d = ST_CP_RD;
        if (wrap) begin
          i_d = '0;
          if (phase_q == PH_RES_MUL) begin
            phase_d = PH_BASE_MUL;
            state_d = ST_MUL_RD;
          end else begin
            pw_d    = pw_q >> 1;
            state_d = ST_BIT;
          end
        end
      end
      ST_BIT: begin
        if (pw_q == '0) begin
          state_d = ST_EM_RD;
        end else if (pw_q[0]) begin
          phase_d = PH_RES_MUL;
          state_d = ST_MUL_RD;
        end else begin
          phase_d = PH_BASE_MUL;
          state_d = ST_MUL_RD;
        end
      end
      ST_EM_RD: begin
        cmd_o.a_addr = wm_addr(RG_RES, i_q, j_q);
        state_d = ST_EM_OUT;
      end
      ST_EM_OUT: begin
        cmd_o.emit = 1'b1;
        j_d = (j_q == nl_q) ? '0 : j_q + IdxW'(1);
        i_d = (j_q == nl_q) ? i_q + IdxW'(1) : i_q;
        state_d = ST_EM_RD;
        if (wrap) begin
          i_d     = '0;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: sim/tb.sv
// Testbench for the modular matrix power block: directed and random words checked against a predictor.
`timescale 1ns / 100ps

module tb;
  import mmp_pkg::*;

  typedef struct {
    logic [IdxW-1:0] row;
    logic [IdxW-1:0] col;
    logic [ValW-1:0] value;
    logic            last;
  } entry_t;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_RUN  = 1'b1;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            psel = 1'b0;
  logic            penable = 1'b0;
  logic            pwrite = 1'b0;
  logic [2:0]      paddr = '0;
  logic [31:0]     pwdata = '0;
  logic [31:0]     prdata;
  logic            pready;
  logic            start = 1'b0;
  logic            busy;
  logic            operation_i = 1'b0;
  logic [IdxW-1:0] row_i = '0;
  logic [IdxW-1:0] col_i = '0;
  logic [ValW-1:0] value_i = '0;
  logic [ValW-1:0] power_i = '0;
  logic            result_valid_o;
  logic [IdxW-1:0] out_row_o;
  logic [IdxW-1:0] out_col_o;
  logic [ValW-1:0] out_value_o;
  logic            last_o;

  modular_matrix_power dut (.*);

  logic [ValW-1:0]  modulus_q;
  logic [SizeW-1:0] size_q;
  logic [ValW-1:0]  src_m  [Cells];
  logic [ValW-1:0]  base_m [Cells];
  logic [ValW-1:0]  res_m  [Cells];
  logic [ValW-1:0]  prod_m [Cells];
  entry_t           pending_entries[$];
  int               mismatches = 0;
  int               items_sent = 0;

  initial forever #10 clk_i = ~clk_i;

  initial begin
    #1_500_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Product of result or base with base, over the n by n block, into prod_m.
  task automatic multiply(input bit res_times_base, input int n, input longint unsigned m);
    longint unsigned a, b, acc;
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        acc = 0;
        for (int k = 0; k < n; k++) begin
          a = res_times_base ? 64'(res_m[i*MaxSize+k]) : 64'(base_m[i*MaxSize+k]);
          b = 64'(base_m[k*MaxSize+j]);
          acc = (acc + (a * b) % m) % m;
        end
        prod_m[i*MaxSize+j] = acc[ValW-1:0];
      end
    end
  endtask

  task automatic predict_power(input logic [ValW-1:0] pw);
    longint unsigned m;
    int n;
    entry_t e;
    m = (modulus_q == 0) ? 1 : modulus_q;
    n = (size_q == 0) ? 1 : (size_q > MaxSize) ? MaxSize : size_q;
    for (int c = 0; c < Cells; c++) begin
      base_m[c] = src_m[c];
      res_m[c] = '0;
    end
    for (int i = 0; i < n; i++) res_m[i*MaxSize+i] = ValW'(1 % m);
    for (int b = 0; b < ValW; b++) begin
      if ((pw >> b) == 0) break;
      if (pw[b]) begin
        multiply(1'b1, n, m);
        for (int c = 0; c < Cells; c++) res_m[c] = prod_m[c];
      end
      multiply(1'b0, n, m);
      for (int c = 0; c < Cells; c++) base_m[c] = prod_m[c];
    end
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        e.row = IdxW'(i);
        e.col = IdxW'(j);
        e.value = res_m[i*MaxSize+j];
        e.last = (i == n - 1) && (j == n - 1);
        pending_entries.push_back(e);
      end
    end
  endtask

  always @(posedge clk_i) begin
    entry_t e;
    if (rst_ni && result_valid_o) begin
      if (pending_entries.size() == 0) begin
        $display("%0t: unexpected word row %0d col %0d value %0d last %0d", $time,
                 out_row_o, out_col_o, out_value_o, last_o);
        mismatches++;
      end else begin
        e = pending_entries.pop_front();
        if (out_row_o !== e.row || out_col_o !== e.col || out_value_o !== e.value ||
            last_o !== e.last) begin
          $display("%0t: expected row %0d col %0d value %0d last %0d, got %0d %0d %0d %0d",
                   $time, e.row, e.col, e.value, e.last,
                   out_row_o, out_col_o, out_value_o, last_o);
          mismatches++;
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  task automatic send_word(input logic op, input logic [IdxW-1:0] r, input logic [IdxW-1:0] c,
                           input logic [ValW-1:0] v, input logic [ValW-1:0] pw);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    operation_i <= op;
    row_i <= r;
    col_i <= c;
    value_i <= v;
    power_i <= pw;
    do @(posedge clk_i); while (busy);
    items_sent++;
    if (op == OP_LOAD) src_m[{r, c}] = v;
    else predict_power(pw);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_entries.size() != 0 || busy) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_e idx, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(4 * idx);
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == CFG_MODULUS) modulus_q = data[ValW-1:0];
    else size_q = data[SizeW-1:0];
  endtask

  task automatic configure(input logic [31:0] m, input logic [31:0] n);
    wait_idle();
    write_reg(CFG_MODULUS, m);
    write_reg(CFG_SIZE, n);
  endtask

  task automatic test_reset_state();
    send_word(OP_RUN, 3'd7, 3'd7, '1, 31'd5);
    send_word(OP_RUN, '0, '0, '0, 31'd0);
  endtask

  task automatic test_extremes();
    configure(32'h7FFF_FFFF, 32'd3);
    send_word(OP_LOAD, 3'd0, 3'd0, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_word(OP_LOAD, 3'd0, 3'd1, 31'h7FFF_FFFE, '0);
    send_word(OP_LOAD, 3'd1, 3'd0, 31'd1, '0);
    send_word(OP_LOAD, 3'd2, 3'd2, 31'h7FFF_FFFF, '0);
    send_word(OP_LOAD, 3'd7, 3'd7, 31'h5555_5555, '0);
    send_word(OP_RUN, 3'd7, 3'd7, 31'h7FFF_FFFF, 31'd1);
    send_word(OP_RUN, '0, '0, '0, 31'd6);
    configure(32'd1000, 32'd1);
    send_word(OP_RUN, '0, '0, '0, 31'h7FFF_FFFF);
    send_word(OP_RUN, '0, '0, '0, 31'h4000_0000);
    configure(32'd97, 32'd8);
    send_word(OP_RUN, '0, '0, '0, 31'd2);
    send_word(OP_RUN, '0, '0, '0, 31'd0);
  endtask

  task automatic test_special_configs();
    configure(32'd1, 32'd2);
    send_word(OP_RUN, '0, '0, '0, 31'd0);
    send_word(OP_RUN, '0, '0, '0, 31'd3);
    configure(32'd0, 32'd0);
    send_word(OP_RUN, '0, '0, '0, 31'd0);
    send_word(OP_RUN, '0, '0, '0, 31'd9);
    configure(32'hFFFF_FFFF, 32'd15);
    send_word(OP_RUN, '0, '0, '0, 31'd1);
    configure(32'd13, 32'hFFFF_FFF9);
    send_word(OP_RUN, '0, '0, '0, 31'd0);
  endtask

  task automatic test_random();
    int n, bits, loads;
    logic [31:0] m;
    logic [ValW-1:0] v, pw;
    while (items_sent < 220) begin
      case ($urandom_range(0, 9))
        0, 1, 2: n = 1;
        3, 4, 5: n = 2;
        6, 7:    n = 3;
        8:       n = 4;
        default: n = $urandom_range(5, 8);
      endcase
      case ($urandom_range(0, 5))
        0:       m = $urandom_range(1, 20);
        1:       m = 32'h7FFF_FFFF - $urandom_range(0, 3);
        2:       m = $urandom;
        default: m = $urandom & 32'h7FFF_FFFF;
      endcase
      configure(m, 32'(n));
      loads = $urandom_range(0, n * n > 6 ? 6 : n * n);
      for (int l = 0; l < loads; l++) begin
        v = ($urandom_range(0, 3) == 0) ? ValW'($urandom_range(0, 9)) : ValW'($urandom);
        if ($urandom_range(0, 3) == 0)
          send_word(OP_LOAD, 3'($urandom), 3'($urandom), v, ValW'($urandom));
        else
          send_word(OP_LOAD, 3'($urandom_range(0, n - 1)), 3'($urandom_range(0, n - 1)),
                    v, ValW'($urandom));
      end
      case (n)
        1:       bits = $urandom_range(0, 31);
        2:       bits = $urandom_range(0, 16);
        3:       bits = $urandom_range(0, 8);
        4:       bits = $urandom_range(0, 4);
        default: bits = $urandom_range(0, 2);
      endcase
      pw = (bits == 0) ? '0 : ValW'(($urandom | 32'h8000_0000) >> (32 - bits));
      send_word(OP_RUN, 3'($urandom), 3'($urandom), ValW'($urandom), pw);
    end
  endtask

  initial begin
    modulus_q = ModReset;
    size_q = SizeReset;
    for (int c = 0; c < Cells; c++) src_m[c] = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_extremes();
    test_special_configs();
    test_random();
    wait_idle();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && pending_entries.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: modular_matrix_power.f
rtl/core/mmp_pkg.sv
rtl/core/mmp_dpath.sv
rtl/core/mmp_ctrl.sv
rtl/core/modular_matrix_power.sv
sim/tb.sv
